FILE: design/fbrc_pkg.sv
// ----------------------------------------------------------------------------
// fbrc_pkg
// Shared types and codes for the free block recycle cache.
// ----------------------------------------------------------------------------
package fbrc_pkg;

  localparam int unsigned SIZE_W = 32;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_ZERO      = 3'd2,
    ST_STORED    = 3'd3,
    ST_NULL_FREE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_ZERO  = 2'd2,
    OP_NULL  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SIZE_W-1:0]  size;
    logic [FIELD_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] result_address;
    logic               evict_valid;
    logic [FIELD_W-1:0] evict_address;
  } rsp_t;

endpackage

FILE: design/fbrc_front.sv
// ----------------------------------------------------------------------------
// fbrc_front
// Accepts items, classifies them and holds them in a two-entry command queue.
// ----------------------------------------------------------------------------
module fbrc_front #(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_action,
  input  logic [fbrc_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [fbrc_pkg::FIELD_W-1:0]  in_block_address,
  input  logic [fbrc_pkg::FIELD_W-1:0]  in_header_word,
  output logic                          cmd_valid,
  input  logic                          cmd_take,
  output fbrc_pkg::cmd_t                cmd
);

  localparam int unsigned AW = (ADDR_BITS < fbrc_pkg::FIELD_W) ? ADDR_BITS : fbrc_pkg::FIELD_W;

  fbrc_pkg::cmd_t q_r [2];
  fbrc_pkg::cmd_t cls;
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       push_ok;
  logic [fbrc_pkg::FIELD_W-1:0] addr_m;

  always_comb begin
    addr_m = '0;
    addr_m[AW-1:0] = in_block_address[AW-1:0];
    cls.addr = addr_m;
    cls.size = in_request_size;
    if (in_action == 1'b0) begin
      cls.op = (in_request_size == '0) ? fbrc_pkg::OP_ZERO : fbrc_pkg::OP_ALLOC;
    end else begin
      cls.op   = (addr_m == '0) ? fbrc_pkg::OP_NULL : fbrc_pkg::OP_FREE;
      cls.size = {in_header_word[fbrc_pkg::SIZE_W-1:2], 2'b00};
    end
  end

  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    wr_nxt  = wr_r;
    if (push_ok) begin
      wr_nxt = ~wr_r;
    end
    if (cmd_take) begin
      rd_nxt = ~rd_r;
    end
    if (push_ok && !cmd_take) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push_ok && cmd_take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push_ok) begin
      q_r[wr_r] <= cls;
    end
  end

endmodule

FILE: design/fbrc_back.sv
// ----------------------------------------------------------------------------
// fbrc_back
// Shift list of freed blocks: parallel size match, priority pick, close-up.
// ----------------------------------------------------------------------------
module fbrc_back #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_take,
  input  fbrc_pkg::cmd_t cmd,
  output logic           out_empty,
  input  logic           out_pop,
  output fbrc_pkg::rsp_t rsp
);

  logic [fbrc_pkg::FIELD_W-1:0] addr_r [ENTRIES];
  logic [fbrc_pkg::SIZE_W-1:0]  size_r [ENTRIES];
  logic [ENTRIES-1:0]           valid_r;
  logic [ENTRIES-1:0]           match;
  logic [ENTRIES-1:0]           below;
  logic [ENTRIES-1:0]           first;
  logic [fbrc_pkg::SIZE_W:0]    limit;
  logic                         full_r;
  fbrc_pkg::rsp_t               rsp_r, rsp_nxt;
  logic [fbrc_pkg::FIELD_W-1:0] hit_addr;
  logic                         hit;

  assign limit = {cmd.size, 1'b0};

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (size_r[i] >= cmd.size)
                 && ({1'b0, size_r[i]} <= limit);
    end
  end

  // prefix "some earlier match" runs one step per slot
  always_comb begin
    below[0] = 1'b0;
    for (int i = 1; i < ENTRIES; i++) begin
      below[i] = below[i-1] | match[i-1];
    end
    first = match & ~below;
    hit = |match;
    hit_addr = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_addr = hit_addr | (addr_r[i] & {fbrc_pkg::FIELD_W{first[i]}});
    end
  end

  assign cmd_take  = cmd_valid && (!full_r || out_pop);
  assign out_empty = !full_r;
  assign rsp       = rsp_r;

  always_comb begin
    rsp_nxt = '0;
    unique case (cmd.op)
      fbrc_pkg::OP_ZERO: rsp_nxt.status = fbrc_pkg::ST_ZERO;
      fbrc_pkg::OP_NULL: rsp_nxt.status = fbrc_pkg::ST_NULL_FREE;
      fbrc_pkg::OP_ALLOC: begin
        rsp_nxt.status = hit ? fbrc_pkg::ST_HIT : fbrc_pkg::ST_MISS;
        rsp_nxt.result_address = hit ? hit_addr : '0;
      end
      fbrc_pkg::OP_FREE: begin
        rsp_nxt.status        = fbrc_pkg::ST_STORED;
        rsp_nxt.evict_valid   = valid_r[ENTRIES-1];
        rsp_nxt.evict_address = valid_r[ENTRIES-1] ? addr_r[ENTRIES-1] : '0;
      end
      default: rsp_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r  <= 1'b0;
      valid_r <= '0;
    end else begin
      if (cmd_take) begin
        full_r <= 1'b1;
      end else if (out_pop) begin
        full_r <= 1'b0;
      end
      if (cmd_take && cmd.op == fbrc_pkg::OP_FREE) begin
        valid_r <= {valid_r[ENTRIES-2:0], 1'b1};
      end else if (cmd_take && cmd.op == fbrc_pkg::OP_ALLOC && hit) begin
        for (int i = 0; i < ENTRIES - 1; i++) begin
          valid_r[i] <= (below[i] || match[i]) ? valid_r[i+1] : valid_r[i];
        end
        valid_r[ENTRIES-1] <= 1'b0;
      end
    end
    if (cmd_take) begin
      rsp_r <= rsp_nxt;
    end
    if (cmd_take && cmd.op == fbrc_pkg::OP_FREE) begin
      addr_r[0] <= cmd.addr;
      size_r[0] <= cmd.size;
      for (int i = 1; i < ENTRIES; i++) begin
        addr_r[i] <= addr_r[i-1];
        size_r[i] <= size_r[i-1];
      end
    end else if (cmd_take && cmd.op == fbrc_pkg::OP_ALLOC && hit) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (below[i] || match[i]) begin
          addr_r[i] <= addr_r[i+1];
          size_r[i] <= size_r[i+1];
        end
      end
    end
  end

endmodule

FILE: design/free_block_recycle_cache.sv
// ----------------------------------------------------------------------------
// free_block_recycle_cache
// Most-recently-used cache of freed blocks in front of a global allocator.
//
//   channel | ports                                    | handshake
//   input   | in_action, in_request_size, in_block_... | in_push / in_full
//   result  | out_status, out_result_address, out_e... | out_empty / out_pop
//
// One item per cycle sustained while results are popped; an item's result passes
// through the command queue, then the list update and result register.
// The list update is a parallel match over all entries and a shift.
// Reset empties the list at once; no clearing pass.
// A stalled result holds the list; the two-entry queue absorbs input meanwhile.
// ----------------------------------------------------------------------------
module free_block_recycle_cache #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_action,
  input  logic [fbrc_pkg::SIZE_W-1:0]  in_request_size,
  input  logic [fbrc_pkg::FIELD_W-1:0] in_block_address,
  input  logic [fbrc_pkg::FIELD_W-1:0] in_header_word,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [fbrc_pkg::STATUS_W-1:0] out_status,
  output logic [fbrc_pkg::FIELD_W-1:0] out_result_address,
  output logic                         out_evict_valid,
  output logic [fbrc_pkg::FIELD_W-1:0] out_evict_address
);

  logic           cmd_valid;
  logic           cmd_take;
  fbrc_pkg::cmd_t cmd;
  fbrc_pkg::rsp_t rsp;

  fbrc_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_action(in_action), .in_request_size(in_request_size),
    .in_block_address(in_block_address), .in_header_word(in_header_word),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  fbrc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .out_empty(out_empty), .out_pop(out_pop), .rsp(rsp)
  );

  assign out_status         = rsp.status;
  assign out_result_address = rsp.result_address;
  assign out_evict_valid    = rsp.evict_valid;
  assign out_evict_address  = rsp.evict_address;

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the free block recycle cache. A directed table
// covers reset state, zero-size and null cases, size-window edges, fill and
// eviction; random alloc/free traffic follows. Every result is checked
// against a local model of the recycle list, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam bit ACT_ALLOC = 1'b0;
  localparam bit ACT_FREE  = 1'b1;

  typedef struct {
    bit                other_act_unused_guard;
  } unused_t;

  typedef struct {
    bit                act;
    logic [31:0]       req;
    logic [31:0]       addr;
    logic [31:0]       hdr;
    bit                fixed;
    fbrc_pkg::status_t st;
    logic [31:0]       res;
    bit                ev;
    logic [31:0]       evaddr;
  } row_t;

  typedef struct {
    fbrc_pkg::status_t st;
    logic [31:0]       res;
    bit                ev;
    logic [31:0]       evaddr;
  } rsp_exp_t;

  logic clk = 0, rst_n = 0;
  logic in_push = 0, in_action = 0, out_pop = 0;
  logic [31:0] in_request_size = 0, in_block_address = 0, in_header_word = 0;
  logic in_full, out_empty, out_evict_valid;
  logic [2:0] out_status;
  logic [31:0] out_result_address, out_evict_address;

  free_block_recycle_cache dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [31:0] list_addr [DEPTH];
  logic [31:0] list_size [DEPTH];
  int          list_cnt = 0;
  rsp_exp_t    pending_rsp [$];
  int          errors = 0, n_items = 0, n_hits = 0, n_evicts = 0;
  bit          stim_done = 0;

  function automatic rsp_exp_t cache_predict(bit act, logic [31:0] req,
                                             logic [31:0] addr, logic [31:0] hdr);
    rsp_exp_t r;
    logic [32:0] lim;
    r = '{fbrc_pkg::ST_MISS, 32'd0, 1'b0, 32'd0};
    if (act == ACT_ALLOC) begin
      lim = {req, 1'b0};
      if (req == 0) begin
        r.st = fbrc_pkg::ST_ZERO;
        return r;
      end
      for (int i = 0; i < list_cnt; i++) begin
        if (list_size[i] >= req && {1'b0, list_size[i]} <= lim) begin
          r.st = fbrc_pkg::ST_HIT;
          r.res = list_addr[i];
          for (int j = i; j < list_cnt - 1; j++) begin
            list_addr[j] = list_addr[j+1];
            list_size[j] = list_size[j+1];
          end
          list_cnt--;
          return r;
        end
      end
      return r;
    end
    if (addr == 0) begin
      r.st = fbrc_pkg::ST_NULL_FREE;
      return r;
    end
    if (list_cnt == DEPTH) begin
      r.ev = 1;
      r.evaddr = list_addr[DEPTH-1];
      list_cnt--;
    end
    for (int i = list_cnt; i > 0; i--) begin
      list_addr[i] = list_addr[i-1];
      list_size[i] = list_size[i-1];
    end
    list_addr[0] = addr;
    list_size[0] = hdr & ~32'h3;
    list_cnt++;
    r.st = fbrc_pkg::ST_STORED;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(bit act, logic [31:0] req, logic [31:0] addr, logic [31:0] hdr,
                           bit fixed, rsp_exp_t fx);
    rsp_exp_t r;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_push <= 0;
      repeat (g) @(posedge clk);
    end
    in_push <= 1;
    in_action <= act;
    in_request_size <= req;
    in_block_address <= addr;
    in_header_word <= hdr;
    @(posedge clk);
    while (in_full) @(posedge clk);
    r = cache_predict(act, req, addr, hdr);
    if (fixed && r != fx) begin
      $display("%0t table row disagrees with model: st %0d vs %0d", $time, fx.st, r.st);
      errors++;
    end
    pending_rsp = {pending_rsp, (fixed ? fx : r)};
    if (r.st == fbrc_pkg::ST_HIT) n_hits++;
    if (r.ev) n_evicts++;
    n_items++;
  endtask

  // drive the result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t unexpected result status %0d", $time, out_status);
          errors++;
        end else begin
          rsp_exp_t e;
          e = pending_rsp.pop_front();
          if (out_status !== e.st)
            $display("%0t status exp %0d got %0d", $time, e.st, out_status);
          if (out_result_address !== e.res)
            $display("%0t result_address exp %h got %h", $time, e.res, out_result_address);
          if (out_evict_valid !== e.ev)
            $display("%0t evict_valid exp %0d got %0d", $time, e.ev, out_evict_valid);
          if (out_evict_address !== e.evaddr)
            $display("%0t evict_address exp %h got %h", $time, e.evaddr, out_evict_address);
          if (out_status !== e.st || out_result_address !== e.res ||
              out_evict_valid !== e.ev || out_evict_address !== e.evaddr)
            errors++;
        end
      end
      out_pop <= ($urandom_range(0, 99) < 8) ? 1'b0 : ($urandom_range(0, 9) != 0);
    end
  end

  row_t table_rows [$];
  initial begin
    rsp_exp_t fx;
    row_t rw;
    logic [31:0] req, addr, hdr;
    bit act;
    int p;
    table_rows = '{
      '{ACT_ALLOC, 32'd0, 32'd0, 32'd0, 1, fbrc_pkg::ST_ZERO, 32'd0, 0, 32'd0},
      '{ACT_ALLOC, 32'd64, 32'd0, 32'd0, 1, fbrc_pkg::ST_MISS, 32'd0, 0, 32'd0},
      '{ACT_FREE, 32'd0, 32'd0, 32'd100, 1, fbrc_pkg::ST_NULL_FREE, 32'd0, 0, 32'd0},
      '{ACT_FREE, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, fbrc_pkg::ST_STORED, 32'd0, 0,
        32'd0},
      '{ACT_ALLOC, 32'hFFFFFFFF, 32'd0, 32'd0, 1, fbrc_pkg::ST_MISS, 32'd0, 0, 32'd0},
      '{ACT_ALLOC, 32'h80000000, 32'd0, 32'd0, 1, fbrc_pkg::ST_HIT, 32'hFFFFFFFF, 0,
        32'd0},
      '{ACT_FREE, 32'd0, 32'h1000, 32'd67, 1, fbrc_pkg::ST_STORED, 32'd0, 0, 32'd0},
      '{ACT_ALLOC, 32'd65, 32'd0, 32'd0, 1, fbrc_pkg::ST_MISS, 32'd0, 0, 32'd0},
      '{ACT_ALLOC, 32'd31, 32'd0, 32'd0, 1, fbrc_pkg::ST_MISS, 32'd0, 0, 32'd0},
      '{ACT_ALLOC, 32'd32, 32'd0, 32'd0, 1, fbrc_pkg::ST_HIT, 32'h1000, 0, 32'd0},
      '{ACT_FREE, 32'hFFFFFFFF, 32'h2000, 32'd128, 0, fbrc_pkg::ST_MISS, 32'd0, 0, 32'd0},
      '{ACT_FREE, 32'd0, 32'h3000, 32'd130, 0, fbrc_pkg::ST_MISS, 32'd0, 0, 32'd0},
      '{ACT_ALLOC, 32'd128, 32'h5555, 32'h5555, 0, fbrc_pkg::ST_MISS, 32'd0, 0, 32'd0}
    };
    for (int i = 0; i < 18; i++)
      table_rows = {table_rows, row_t'{ACT_FREE, 32'd0, 32'h100 * (i + 1),
                                       32'd16 * (i + 1), 0, fbrc_pkg::ST_MISS, 32'd0, 0,
                                       32'd0}};
    table_rows = {table_rows, row_t'{ACT_ALLOC, 32'd8, 32'd0, 32'd0, 0, fbrc_pkg::ST_MISS,
                                     32'd0, 0, 32'd0}};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (table_rows[i]) begin
      rw = table_rows[i];
      fx = '{rw.st, rw.res, rw.ev, rw.evaddr};
      send_item(rw.act, rw.req, rw.addr, rw.hdr, rw.fixed, fx);
    end
    for (int k = 0; k < 1000; k++) begin
      p = $urandom_range(0, 99);
      act = (p < 50);
      hdr = $urandom;
      addr = $urandom;
      req = $urandom;
      if (p < 3) addr = 0;
      if (p >= 50 && p < 53) req = 0;
      if ($urandom_range(0, 9) < 8) hdr = {22'd0, hdr[9:0]};
      if (p >= 53 && p < 90 && list_cnt > 0)
        req = list_size[$urandom_range(0, list_cnt - 1)] >> $urandom_range(0, 1);
      else if ($urandom_range(0, 9) < 7) req = {22'd0, req[9:0]};
      send_item(act, req, addr, hdr, 0, fx);
    end
    in_push <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d items with %0d cache hits and %0d evictions.",
             n_items, n_hits, n_evicts);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

FILE: sim.f
design/fbrc_pkg.sv
design/fbrc_front.sv
design/fbrc_back.sv
design/free_block_recycle_cache.sv
sim/tb_top.sv
